/* hdl/sqt_pkg.sv */
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared types and constants for the shell quote tokenizer.
// ----------------------------------------------------------------------------
package sqt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int SLOTS       = 4;
   localparam int SLOT_IDX_W  = $clog2(SLOTS);

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_BACKQUOTE = 8'h60;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   typedef enum logic [1:0] {
      KIND_CHAR     = 2'd0,
      KIND_WORD_END = 2'd1,
      KIND_LINE_END = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] byte_val;
      kind_type   kind;
      logic       unm;
   } result_type;

   // all results caused by one input item, slot 0 first
   typedef struct packed {
      result_type [SLOTS-1:0] slot;
      logic [SLOT_IDX_W-1:0]  last_idx;
   } bundle_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic dq_escapable(input logic [7:0] c);
      return (c == CH_BACKSLASH) || (c == CH_DQUOTE) || (c == CH_DOLLAR) ||
             (c == CH_BACKQUOTE) || (c == CH_NEWLINE);
   endfunction

endpackage

/* hdl/sqt_front.sv */
// ----------------------------------------------------------------------------
// sqt_front
// Classifies each input byte against the quote state and builds the bundle
// of results it causes.
// ----------------------------------------------------------------------------
module sqt_front import sqt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       byte_valid,
   input  logic       line_end,
   output logic       wr_en,
   output bundle_type wr_data
);

   logic sq_ff, sq_in;
   logic dq_ff, dq_in;
   logic esc_ff, esc_in;
   logic pb_ff, pb_in;
   logic wo_ff, wo_in;
   logic [2:0] count;

   always_comb begin : classify
      logic [2:0] n;
      logic       done;
      result_type slot [SLOTS];
      sq_in  = sq_ff;
      dq_in  = dq_ff;
      esc_in = esc_ff;
      pb_in  = pb_ff;
      wo_in  = wo_ff;
      n      = 3'd0;
      done   = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         slot[i] = '{byte_val: 8'h00, kind: KIND_CHAR, unm: 1'b0};
      end

      if (byte_valid) begin
         if (pb_in) begin
            pb_in = 1'b0;
            if (dq_escapable(in_byte)) begin
               slot[n[1:0]] = '{byte_val: in_byte, kind: KIND_CHAR, unm: 1'b0};
               n = n + 3'd1;
               wo_in = 1'b1;
               done = 1'b1;
            end else begin
               slot[n[1:0]] = '{byte_val: CH_BACKSLASH, kind: KIND_CHAR, unm: 1'b0};
               n = n + 3'd1;
               wo_in = 1'b1;
            end
         end
         if (!done) begin
            priority if (esc_in) begin
               esc_in = 1'b0;
               slot[n[1:0]] = '{byte_val: in_byte, kind: KIND_CHAR, unm: 1'b0};
               n = n + 3'd1;
               wo_in = 1'b1;
            end else if (in_byte == CH_BACKSLASH) begin
               priority if (dq_in) begin
                  pb_in = 1'b1;
               end else if (sq_in) begin
                  slot[n[1:0]] = '{byte_val: CH_BACKSLASH, kind: KIND_CHAR, unm: 1'b0};
                  n = n + 3'd1;
                  wo_in = 1'b1;
               end else begin
                  esc_in = 1'b1;
               end
            end else if (in_byte == CH_SQUOTE && !dq_in) begin
               sq_in = !sq_in;
            end else if (in_byte == CH_DQUOTE && !sq_in) begin
               dq_in = !dq_in;
            end else if (is_blank(in_byte) && !sq_in && !dq_in) begin
               if (wo_in) begin
                  wo_in = 1'b0;
                  slot[n[1:0]] = '{byte_val: 8'h00, kind: KIND_WORD_END, unm: 1'b0};
                  n = n + 3'd1;
               end
            end else begin
               slot[n[1:0]] = '{byte_val: in_byte, kind: KIND_CHAR, unm: 1'b0};
               n = n + 3'd1;
               wo_in = 1'b1;
            end
         end
      end

      if (line_end) begin
         // flush a held backslash and the open word, then close the line
         if (pb_in) begin
            slot[n[1:0]] = '{byte_val: CH_BACKSLASH, kind: KIND_CHAR, unm: 1'b0};
            n = n + 3'd1;
            wo_in = 1'b1;
         end
         if (wo_in) begin
            slot[n[1:0]] = '{byte_val: 8'h00, kind: KIND_WORD_END, unm: 1'b0};
            n = n + 3'd1;
         end
         slot[n[1:0]] = '{byte_val: 8'h00, kind: KIND_LINE_END, unm: sq_in | dq_in};
         n = n + 3'd1;
         sq_in  = 1'b0;
         dq_in  = 1'b0;
         esc_in = 1'b0;
         pb_in  = 1'b0;
         wo_in  = 1'b0;
      end

      count = n;
      for (int i = 0; i < SLOTS; i++) begin
         wr_data.slot[i] = slot[i];
      end
      wr_data.last_idx = SLOT_IDX_W'(n - 3'd1);
   end

   assign wr_en = accept && (count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff  <= 1'b0;
         dq_ff  <= 1'b0;
         esc_ff <= 1'b0;
         pb_ff  <= 1'b0;
         wo_ff  <= 1'b0;
      end else if (accept) begin
         sq_ff  <= sq_in;
         dq_ff  <= dq_in;
         esc_ff <= esc_in;
         pb_ff  <= pb_in;
         wo_ff  <= wo_in;
      end
   end

endmodule

/* hdl/sqt_queue.sv */
// ----------------------------------------------------------------------------
// sqt_queue
// Short bundle queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module sqt_queue import sqt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  bundle_type wr_data,
   input  logic       rd_en,
   output bundle_type rd_data,
   output logic       full,
   output logic       empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      unique case ({wr_en, rd_en})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/sqt_back.sv */
// ----------------------------------------------------------------------------
// sqt_back
// Walks the slots of the head bundle and drives one result per cycle,
// while the receiver pops, through an output register.
// ----------------------------------------------------------------------------
module sqt_back import sqt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       head_empty,
   output logic       head_rd,
   input  logic       pop,
   output logic       out_empty,
   output logic [7:0] out_byte,
   output logic [1:0] out_kind,
   output logic       out_unm,
   output logic       out_last
);

   logic                  valid_ff, valid_in;
   result_type            res_ff;
   logic                  last_ff;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  load;
   logic                  at_last;

   assign load    = !head_empty && (!valid_ff || pop);
   assign at_last = (idx_ff == head.last_idx);
   assign head_rd = load && at_last;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? '0 : idx_ff + SLOT_IDX_W'(1);
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.slot[idx_ff];
         last_ff <= at_last;
      end
   end

   assign out_empty = !valid_ff;
   assign out_byte  = res_ff.byte_val;
   assign out_kind  = res_ff.kind;
   assign out_unm   = res_ff.unm;
   assign out_last  = last_ff;

endmodule

/* hdl/shell_quote_tokenizer.sv */
// ----------------------------------------------------------------------------
// shell_quote_tokenizer
// Shell-style word splitter with single quotes, double quotes and escapes.
// ----------------------------------------------------------------------------
// One command-line byte is taken per cycle while the bundle queue has room;
// each byte produces zero to four results (characters, end of word, end of
// line), and the result side drains them at one per cycle while the
// receiver pops. Items that yield no result (quotes, an escape backslash,
// repeated blanks) write no bundle and never reach the output. Input and
// output are decoupled by a QUEUE_DEPTH bundle queue plus the output
// register.
module shell_quote_tokenizer import sqt_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_byte_valid,
   input  logic       req_line_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_unmatched_quote,
   output logic       rsp_last
);

   logic       accept;
   logic       q_wr;
   bundle_type q_wr_data;
   logic       q_rd;
   bundle_type q_rd_data;
   logic       q_empty;

   assign accept = req_push && !req_full;

   sqt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .byte_valid (req_byte_valid),
      .line_end   (req_line_end),
      .wr_en      (q_wr),
      .wr_data    (q_wr_data)
   );

   sqt_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_wr_data),
      .rd_en   (q_rd),
      .rd_data (q_rd_data),
      .full    (req_full),
      .empty   (q_empty)
   );

   sqt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_rd_data),
      .head_empty (q_empty),
      .head_rd    (q_rd),
      .pop        (rsp_pop),
      .out_empty  (rsp_empty),
      .out_byte   (rsp_out_byte),
      .out_kind   (rsp_kind),
      .out_unm    (rsp_unmatched_quote),
      .out_last   (rsp_last)
   );

endmodule

/* hdl/sqt_checker.sv */
// ----------------------------------------------------------------------------
// sqt_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module sqt_checker import sqt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic       rsp_unmatched_quote,
   input logic       rsp_last
);

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_kind == KIND_CHAR || rsp_kind == KIND_WORD_END ||
                      rsp_kind == KIND_LINE_END))
      else $error("illegal result kind");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != KIND_CHAR) |-> (rsp_out_byte == 8'h00))
      else $error("word or line marker carries a byte");

   a_unm_on_eol: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unmatched_quote) |-> (rsp_kind == KIND_LINE_END))
      else $error("unmatched quote flag outside end of line");

   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_LINE_END) |-> rsp_last)
      else $error("end of line is not the final result of its transfer");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte) &&
                                    $stable(rsp_kind) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind shell_quote_tokenizer sqt_checker u_sqt_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_kind            (rsp_kind),
   .rsp_unmatched_quote (rsp_unmatched_quote),
   .rsp_last            (rsp_last)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for shell_quote_tokenizer.
// ----------------------------------------------------------------------------
// A short table of command-line bytes covers quoting, escapes, blanks and
// line ends, and random command lines follow it. Both sides idle in random
// bursts. Each accepted item is run through a behavioral tokenizer, and each
// token popped from the block is compared with the oldest predicted token.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sqt_pkg::*;

   typedef struct {
      logic [7:0] ch;
      kind_type   kind;
      logic       unm;
      logic       last;
   } token_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       eol;
      logic       typed;
      logic [7:0] x_ch;
      kind_type   x_kind;
      logic       x_unm;
   } stim_row_type;

   localparam int NUM_ROWS     = 28;
   localparam int RANDOM_ITEMS = 500;
   localparam int CALM_AFTER   = 430;

   // rows with typed set carry their single expected token
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, KIND_LINE_END, 1'b0},
      '{8'h00, 1'b1, 1'b0, 1'b1, 8'h00, KIND_CHAR,     1'b0},
      '{8'hFF, 1'b1, 1'b0, 1'b1, 8'hFF, KIND_CHAR,     1'b0},
      '{8'h20, 1'b1, 1'b0, 1'b1, 8'h00, KIND_WORD_END, 1'b0},
      '{8'h27, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h27, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h22, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h22, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h0D, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h27, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b1, 8'h5C, KIND_CHAR,     1'b0},
      '{8'h27, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h0C, 1'b1, 1'b0, 1'b1, 8'h00, KIND_WORD_END, 1'b0},
      '{8'h22, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h41, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h0A, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h62, 1'b1, 1'b1, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h20, 1'b1, 1'b0, 1'b1, 8'h20, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h22, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h5C, 1'b1, 1'b0, 1'b0, 8'h00, KIND_CHAR,     1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00, KIND_CHAR,     1'b0}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       req_byte_valid;
   logic       req_line_end;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_unmatched_quote;
   logic       rsp_last;

   // tokenizer state
   logic in_squote   = 1'b0;
   logic in_dquote   = 1'b0;
   logic escaped     = 1'b0;
   logic held_bslash = 1'b0;
   logic in_word     = 1'b0;

   token_type tokens_due[$];
   token_type item_tokens[$];
   int        errors     = 0;
   bit        calm       = 1'b0;
   int        gap_odds   = 10;
   int        stall_odds = 10;
   logic      cur_typed  = 1'b0;
   token_type cur_want;

   shell_quote_tokenizer dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_in_byte         (req_in_byte),
      .req_byte_valid      (req_byte_valid),
      .req_line_end        (req_line_end),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_kind            (rsp_kind),
      .rsp_unmatched_quote (rsp_unmatched_quote),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_token(input logic [7:0] ch, input kind_type kind,
                                     input logic unm);
      token_type t;
      t.ch   = ch;
      t.kind = kind;
      t.unm  = unm;
      t.last = 1'b0;
      if (kind == KIND_CHAR) begin
         in_word = 1'b1;
      end
      item_tokens.insert(item_tokens.size(), t);
   endfunction

   function automatic void take_byte(input logic [7:0] c);
      logic blank;
      blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      if (held_bslash) begin
         held_bslash = 1'b0;
         if (c inside {CH_BACKSLASH, CH_DQUOTE, CH_DOLLAR, CH_BACKQUOTE, CH_NEWLINE}) begin
            add_token(c, KIND_CHAR, 1'b0);
            return;
         end
         add_token(CH_BACKSLASH, KIND_CHAR, 1'b0);
      end
      if (escaped) begin
         escaped = 1'b0;
         add_token(c, KIND_CHAR, 1'b0);
         return;
      end
      if (c == CH_BACKSLASH) begin
         if (in_dquote) begin
            held_bslash = 1'b1;
         end else if (in_squote) begin
            add_token(CH_BACKSLASH, KIND_CHAR, 1'b0);
         end else begin
            escaped = 1'b1;
         end
      end else if (c == CH_SQUOTE && !in_dquote) begin
         in_squote = !in_squote;
      end else if (c == CH_DQUOTE && !in_squote) begin
         in_dquote = !in_dquote;
      end else if (blank && !in_squote && !in_dquote) begin
         if (in_word) begin
            in_word = 1'b0;
            add_token(8'h00, KIND_WORD_END, 1'b0);
         end
      end else begin
         add_token(c, KIND_CHAR, 1'b0);
      end
   endfunction

   function automatic void tokenize(input logic [7:0] c, input logic valid,
                                    input logic eol);
      item_tokens.delete();
      if (valid) begin
         take_byte(c);
      end
      if (eol) begin
         if (held_bslash) begin
            add_token(CH_BACKSLASH, KIND_CHAR, 1'b0);
         end
         if (in_word) begin
            add_token(8'h00, KIND_WORD_END, 1'b0);
         end
         add_token(8'h00, KIND_LINE_END, in_squote | in_dquote);
         in_squote   = 1'b0;
         in_dquote   = 1'b0;
         escaped     = 1'b0;
         held_bslash = 1'b0;
         in_word     = 1'b0;
      end
      if (item_tokens.size() > 0) begin
         item_tokens[item_tokens.size() - 1].last = 1'b1;
      end
   endfunction

   // predict on every accepted item, check every accepted token
   always @(posedge clock) begin : monitor
      token_type want;
      if (!reset && req_push && !req_full) begin
         tokenize(req_in_byte, req_byte_valid, req_line_end);
         if (cur_typed) begin
            tokens_due.insert(tokens_due.size(), cur_want);
         end else begin
            foreach (item_tokens[i]) begin
               tokens_due.insert(tokens_due.size(), item_tokens[i]);
            end
         end
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (tokens_due.size() == 0) begin
            $error("unexpected token: kind %0d byte %02h", rsp_kind, rsp_out_byte);
            errors++;
         end else begin
            want = tokens_due.pop_front();
            if (rsp_out_byte !== want.ch) begin
               $error("out_byte: expected %02h, got %02h", want.ch, rsp_out_byte);
               errors++;
            end
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               errors++;
            end
            if (rsp_unmatched_quote !== want.unm) begin
               $error("unmatched_quote: expected %0d, got %0d", want.unm,
                      rsp_unmatched_quote);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // receiver: stall in bursts while not calm
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_odds) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send(input logic [7:0] c, input logic valid, input logic eol);
      req_in_byte    <= c;
      req_byte_valid <= valid;
      req_line_end   <= eol;
      req_push       <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic hold_off();
      if (!calm && $urandom_range(0, 99) < gap_odds) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] blanks [6];
      blanks = '{CH_SPACE, CH_TAB, CH_NEWLINE, 8'h0B, 8'h0C, CH_CR};
      case ($urandom_range(0, 15))
         0, 1:    return blanks[$urandom_range(0, 5)];
         2:       return CH_SQUOTE;
         3:       return CH_DQUOTE;
         4, 5:    return CH_BACKSLASH;
         6:       return $urandom_range(0, 1) ? CH_DOLLAR : CH_BACKQUOTE;
         7:       return 8'($urandom_range(0, 255));
         8:       return 8'($urandom_range(8'h80, 8'hFF));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   initial begin : driver
      int   sent;
      int   len;
      bit   eol_on_byte;
      bit   noisy_line;
      logic [7:0] c;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_in_byte    = 8'h00;
      req_byte_valid = 1'b0;
      req_line_end   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         hold_off();
         cur_typed     = DIRECTED[i].typed;
         cur_want.ch   = DIRECTED[i].x_ch;
         cur_want.kind = DIRECTED[i].x_kind;
         cur_want.unm  = DIRECTED[i].x_unm;
         cur_want.last = 1'b1;
         send(DIRECTED[i].ch, DIRECTED[i].valid, DIRECTED[i].eol);
      end
      cur_typed = 1'b0;

      // drain fully before the random lines start
      req_push <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      @(negedge clock);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm        = (sent > CALM_AFTER);
         gap_odds    = calm ? 0 : $urandom_range(0, 2) * 12;
         stall_odds  = calm ? 0 : $urandom_range(0, 2) * 12;
         len         = $urandom_range(0, 12);
         eol_on_byte = $urandom_range(0, 1);
         noisy_line  = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < len; k++) begin
            hold_off();
            if ($urandom_range(0, 19) == 0) begin
               send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            c = noisy_line ? 8'($urandom_range(0, 255)) : pick_byte();
            send(c, 1'b1, eol_on_byte && (k == len - 1));
            sent++;
         end
         if (!eol_on_byte || len == 0) begin
            hold_off();
            send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
         end
      end
      req_push <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && tokens_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
hdl/sqt_pkg.sv
hdl/sqt_front.sv
hdl/sqt_queue.sv
hdl/sqt_back.sv
hdl/shell_quote_tokenizer.sv
hdl/sqt_checker.sv
test/tb.sv
